// ===== src/key_debounce_autorepeat_assert.svh =====
// key_debounce_autorepeat_assert.svh: assertion macros for the key debouncer RTL.
// Each macro expects the signals clock and reset to be visible where it is used.
`ifndef KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/kda_pkg.sv =====
// kda_pkg: types and constants of the key debouncer with auto-repeat.
// No dependencies; used by key_debounce_autorepeat.
`timescale 1ns / 1ps

package kda_pkg;

   // Widths fixed by the transaction fields.
   localparam int RAW_KEYS_W  = 8;
   localparam int KEY_INDEX_W = 3;
   localparam int KIND_W      = 2;
   localparam int COUNT_W     = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // The disagreement counter saturates here.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_DEBOUNCE_COUNT     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_FIRST_DELAY = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_PERIOD      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_ON          = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_REPEAT_KEY_SELECT  = 3'd4;

   typedef logic [KEY_INDEX_W-1:0] key_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PRESSED  = 2'd0,
      KIND_RELEASED = 2'd1,
      KIND_HELD     = 2'd2
   } event_kind_type;

   // One event without its time stamp; the key index sits in the low bits.
   typedef struct packed {
      event_kind_type kind;
      key_index_type  key;
   } kda_event_type;

endpackage

// ===== src/kda_ram.sv =====
// kda_ram: generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module kda_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/key_debounce_autorepeat.sv =====
// key_debounce_autorepeat: top level of the keypad debouncer with auto-repeat.
// Depends on kda_pkg, kda_ram and the macros in key_debounce_autorepeat_assert.svh.
`timescale 1ns / 1ps

// Each req transaction carries one raw sample of the key levels and its tick stamp.
// The keys are visited in order, one per clock cycle unless the rsp side stalls
// or a key needs the hold state, reading and writing back their disagreement
// counter and repeat deadline in a small state memory; the debounced levels sit
// in a register. Every pressed, released or held event leaves as one rsp
// transaction stamped with the sample's tick, and the last event of a sample
// carries tlast; a sample that causes nothing gives no transaction. A key that
// reports a press and a held event from the same sample visits the hold state
// as well; the pace is set by the single read port of the state memory, which
// serves one key per cycle. A new sample is taken as soon as the previous one is
// finished, while its last event may still wait in the output register. After
// reset the memory needs no clearing pass: a valid bit per key makes an unwritten
// entry read as zero. Delays and periods are in ticks, a deadline of zero means
// disarmed, and a debounce count of zero behaves as one. The user must write
// configuration through the csr port only while no sample is in progress; the
// block itself does not enforce this.
module key_debounce_autorepeat #(
   parameter int KEY_COUNT  = 8,
   parameter int TICK_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,

   // Sample channel.
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // raw_keys [7:0], now_tick [8 +: TICK_WIDTH], zero padding above.
   input  logic [((kda_pkg::RAW_KEYS_W + TICK_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,

   // Event channel.
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // key_index [2:0], event_kind [4:3], event_time [5 +: TICK_WIDTH], zero padding above.
   output logic [((kda_pkg::KEY_INDEX_W + kda_pkg::KIND_W + TICK_WIDTH + 7) / 8) * 8 - 1:0]
                                                     rsp_tdata,
   output logic                                      rsp_tlast,

   // Configuration write port.
   input  logic                                      csr_we,
   input  logic [kda_pkg::CSR_ADDR_W-1:0]            csr_addr,
   input  logic [kda_pkg::CSR_DATA_W-1:0]            csr_wdata
);

`include "key_debounce_autorepeat_assert.svh"

   localparam int RSP_W   = ((kda_pkg::KEY_INDEX_W + kda_pkg::KIND_W + TICK_WIDTH + 7) / 8) * 8;
   localparam int AW      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int DW      = kda_pkg::COUNT_W + TICK_WIDTH;
   localparam logic [AW-1:0] KEY_LAST = AW'(KEY_COUNT - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_HOLD,
      S_FLUSH
   } state_type;

   // Configuration registers.
   logic [kda_pkg::COUNT_W-1:0]    deb_count_ff;
   logic [kda_pkg::CSR_DATA_W-1:0] rep_first_ff;
   logic [kda_pkg::CSR_DATA_W-1:0] rep_period_ff;
   logic                           rep_on_ff;
   logic [kda_pkg::RAW_KEYS_W-1:0] rep_sel_ff;

   // Control and state registers.
   state_type               state_ff, state_in;
   logic [AW-1:0]           key_ff, key_in;
   logic [KEY_COUNT-1:0]    deb_ff, deb_in;
   logic [KEY_COUNT-1:0]    valid_ff, valid_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [KEY_COUNT-1:0]    raw_ff, raw_in;
   logic [TICK_WIDTH-1:0]   now_ff, now_in;
   kda_pkg::kda_event_type  pend_ev_ff, pend_ev_in;
   kda_pkg::kda_event_type  rsp_event_ff, rsp_event_in;
   logic [TICK_WIDTH-1:0]   rsp_time_ff, rsp_time_in;
   logic                    rsp_last_ff, rsp_last_in;

   // State memory: {repeat deadline, disagreement counter} per key.
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [DW-1:0]           rd_data;
   logic                    wr_en;
   logic [DW-1:0]           wr_data;

   // Per-key evaluation.
   logic [DW-1:0]                 entry;
   logic [kda_pkg::COUNT_W-1:0]   cnt_old, cnt_inc, cnt_new, need;
   logic [TICK_WIDTH-1:0]         dl_old, dl_mid, dl_new;
   logic [TICK_WIDTH-1:0]         first_t, period_t, neg_first, sum_first, sum_period, diff_old;
   logic                          raw_on, st_on, disagree, flip, pressed, released;
   logic                          deb_new_k, reach_mid, held, ev_need;
   logic                          rsp_free, can_emit, emit_req, advance;
   kda_pkg::kda_event_type        emit_ev;
   logic [AW-1:0]                 key_nx;

   kda_ram #(
      .WIDTH (DW),
      .DEPTH (KEY_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (key_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         deb_count_ff  <= kda_pkg::COUNT_W'(1);
         rep_first_ff  <= '0;
         rep_period_ff <= '0;
         rep_on_ff     <= 1'b0;
         rep_sel_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            kda_pkg::REG_DEBOUNCE_COUNT: begin
               deb_count_ff <= csr_wdata[kda_pkg::COUNT_W-1:0];
            end
            kda_pkg::REG_REPEAT_FIRST_DELAY: begin
               rep_first_ff <= csr_wdata;
            end
            kda_pkg::REG_REPEAT_PERIOD: begin
               rep_period_ff <= csr_wdata;
            end
            kda_pkg::REG_REPEAT_ON: begin
               rep_on_ff <= csr_wdata[0];
            end
            kda_pkg::REG_REPEAT_KEY_SELECT: begin
               rep_sel_ff <= csr_wdata[kda_pkg::RAW_KEYS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // An entry that has never been written reads as its reset value, zero.
   assign entry   = valid_ff[key_ff] ? rd_data : '0;
   assign cnt_old = entry[kda_pkg::COUNT_W-1:0];
   assign dl_old  = entry[DW-1:kda_pkg::COUNT_W];

   assign raw_on   = raw_ff[key_ff];
   assign st_on    = deb_ff[key_ff];
   assign disagree = raw_on != st_on;
   assign need     = (deb_count_ff == '0) ? kda_pkg::COUNT_W'(1) : deb_count_ff;
   assign cnt_inc  = (cnt_old == kda_pkg::COUNT_MAX) ? cnt_old
                                                     : cnt_old + kda_pkg::COUNT_W'(1);
   assign flip     = disagree && (cnt_inc >= need);
   assign cnt_new  = (disagree && !flip) ? cnt_inc : '0;
   assign pressed  = flip && raw_on;
   assign released = flip && !raw_on;
   assign deb_new_k = flip ? raw_on : st_on;

   // Deadline arithmetic, all modulo 2^TICK_WIDTH. The adders work side by side:
   // for a fresh press the distance to the new deadline is simply minus the
   // first delay, so no sum feeds another.
   assign first_t    = TICK_WIDTH'(rep_first_ff);
   assign period_t   = TICK_WIDTH'(rep_period_ff);
   assign neg_first  = '0 - first_t;
   assign sum_first  = now_ff + first_t;
   assign sum_period = now_ff + period_t;
   assign diff_old   = now_ff - dl_old;

   always_comb begin
      if (pressed) begin
         dl_mid    = sum_first;
         reach_mid = !neg_first[TICK_WIDTH-1];
      end else if (released) begin
         dl_mid    = '0;
         reach_mid = 1'b0;
      end else begin
         dl_mid    = dl_old;
         reach_mid = !diff_old[TICK_WIDTH-1];
      end
   end

   assign held = rep_on_ff && rep_sel_ff[key_ff] && deb_new_k && (dl_mid != '0) && reach_mid;

   always_comb begin
      if (!held) begin
         dl_new = dl_mid;
      end else if (period_t != '0) begin
         dl_new = sum_period;
      end else begin
         dl_new = '0;
      end
   end

   assign wr_data = {dl_new, cnt_new};
   assign ev_need = flip || held;
   assign key_nx  = key_ff + AW'(1);

   // An event first waits in the pending slot, so that the last one of a sample
   // can be marked; the older pending event moves on to the output register.
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign can_emit = !pend_valid_ff || rsp_free;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      deb_in        = deb_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_ev_in    = pend_ev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_event_in  = rsp_event_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_last_in   = rsp_last_ff;
      raw_in        = raw_ff;
      now_in        = now_ff;
      rd_en         = 1'b0;
      rd_addr       = key_nx;
      wr_en         = 1'b0;
      emit_req      = 1'b0;
      emit_ev       = pend_ev_ff;
      advance       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata[KEY_COUNT-1:0];
               now_in   = req_tdata[kda_pkg::RAW_KEYS_W +: TICK_WIDTH];
               rd_en    = 1'b1;
               rd_addr  = '0;
               key_in   = '0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!ev_need || can_emit) begin
               wr_en            = 1'b1;
               valid_in[key_ff] = 1'b1;
               deb_in[key_ff]   = deb_new_k;
               emit_req         = ev_need;
               if (flip) begin
                  emit_ev.kind = pressed ? kda_pkg::KIND_PRESSED : kda_pkg::KIND_RELEASED;
               end else begin
                  emit_ev.kind = kda_pkg::KIND_HELD;
               end
               emit_ev.key = kda_pkg::key_index_type'(key_ff);
               if (flip && held) begin
                  state_in = S_HOLD;
               end else begin
                  advance = 1'b1;
               end
            end
         end
         S_HOLD: begin
            if (can_emit) begin
               emit_req     = 1'b1;
               emit_ev.kind = kda_pkg::KIND_HELD;
               emit_ev.key  = kda_pkg::key_index_type'(key_ff);
               advance      = 1'b1;
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_event_in  = pend_ev_ff;
               rsp_time_in   = now_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit_req) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_event_in = pend_ev_ff;
            rsp_time_in  = now_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_ev_in    = emit_ev;
      end

      // Move to the next key, reading its entry so it is ready next cycle.
      if (advance) begin
         if (key_ff == KEY_LAST) begin
            state_in = S_FLUSH;
         end else begin
            rd_en    = 1'b1;
            key_in   = key_nx;
            state_in = S_EVAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         key_ff        <= '0;
         deb_ff        <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_ff        <= key_in;
         deb_ff        <= deb_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      raw_ff       <= raw_in;
      now_ff       <= now_in;
      pend_ev_ff   <= pend_ev_in;
      rsp_event_ff <= rsp_event_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_time_ff, rsp_event_ff});
   assign rsp_tlast  = rsp_last_ff;

   // A new sample must never start while an event of the previous one is pending.
   `KDA_ASSERT_SAME(a_accept_flushed, req_tvalid && req_tready, !pend_valid_ff,
                    "sample accepted with an event still pending")
   // Flushing the pending event always yields a marked final transaction.
   `KDA_ASSERT_NEXT(a_flush_last, state_ff == S_FLUSH && pend_valid_ff && rsp_free,
                    rsp_tvalid && rsp_tlast, "final event of a sample not marked")
   // Held events only appear while auto-repeat is enabled.
   `KDA_ASSERT_SAME(a_held_enabled, rsp_tvalid && rsp_event_ff.kind == kda_pkg::KIND_HELD,
                    rep_on_ff, "held event with auto-repeat off")
   // The key walk never runs past the last key.
   `KDA_ASSERT_SAME(a_key_range, state_ff == S_EVAL || state_ff == S_HOLD,
                    key_ff <= KEY_LAST, "key index out of range")

endmodule
